// File: rtl/pli_pkg.sv
// Package with the shared types and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int DATA_WIDTH  = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int T_FRAC      = 16;

    typedef enum logic
    {
        ACT_APPEND = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_INTERIOR = 2'd0,
        ST_BELOW    = 2'd1,
        ST_ABOVE    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed
    {
        logic                         action;
        logic                         start_req;
        logic signed [DATA_WIDTH-1:0] x_value;
        logic signed [DATA_WIDTH-1:0] y_value;
    } in_item_t;

    typedef struct packed
    {
        logic signed [DATA_WIDTH-1:0] y_out;
        logic [1:0]                   status;
    } out_item_t;

    // Work handed from the table front end to the arithmetic back end.
    typedef struct packed
    {
        logic [1:0]                   status;
        logic signed [DATA_WIDTH-1:0] x_q;
        logic signed [DATA_WIDTH-1:0] x0;
        logic signed [DATA_WIDTH-1:0] x1;
        logic signed [DATA_WIDTH-1:0] y0;
        logic signed [DATA_WIDTH-1:0] y1;
    } job_t;

    typedef enum logic [2:0]
    {
        FS_IDLE,
        FS_READ,
        FS_CHECK,
        FS_FETCH,
        FS_BRACKET,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0]
    {
        BS_IDLE,
        BS_SETUP,
        BS_DIV,
        BS_MUL,
        BS_ROUND,
        BS_OUT
    } back_state_t;

endpackage

// File: rtl/pli_front.sv
// Front end: breakpoint table, append handling and the cursor search.
module pli_front
    import pli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job_data
);

    logic signed [DATA_WIDTH-1:0] mem_x [TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] mem_y [TABLE_DEPTH];

    front_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic signed [DATA_WIDTH-1:0] xq_reg, xq_next;
    job_t job_reg, job_next;

    logic [ADDR_W-1:0] rd_addr;
    logic signed [DATA_WIDTH-1:0] rd_x_reg, rd_y_reg;
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;

    // Table memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= in_data.x_value;
            mem_y[wr_addr] <= in_data.y_value;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FS_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xq_reg  <= xq_next;
        job_reg <= job_next;
    end

    assign in_ready  = (state_reg == FS_IDLE);
    assign job_valid = (state_reg == FS_PUSH);
    assign job_data  = job_reg;

    // Next state: appends finish at once; queries walk the cursor one entry per cycle.
    always_comb
    begin
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] cnt;
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        xq_next     = xq_reg;
        job_next    = job_reg;
        wr_en       = 1'b0;
        cnt         = count_reg;
        base        = in_data.start_req ? '0 : count_reg;
        wr_addr     = base[ADDR_W-1:0];
        rd_addr     = cursor_reg[ADDR_W-1:0];
        case (state_reg)
            FS_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.action == ACT_APPEND)
                    begin
                        if (in_data.start_req)
                        begin
                            cursor_next = '0;
                        end
                        if (base < CNT_W'(TABLE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = base + 1'b1;
                        end
                        else
                        begin
                            count_next = base;
                        end
                    end
                    else
                    begin
                        xq_next = in_data.x_value;
                        if (in_data.start_req)
                        begin
                            cursor_next = '0;
                        end
                        else if (cursor_reg > count_reg)
                        begin
                            cursor_next = count_reg;
                        end
                        state_next = FS_READ;
                    end
                end
            end
            FS_READ:
            begin
                state_next = FS_CHECK;
            end
            FS_CHECK:
            begin
                if (cursor_reg < cnt && xq_reg > rd_x_reg)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    rd_addr     = cursor_next[ADDR_W-1:0];
                    state_next  = FS_CHECK;
                end
                else if (cnt == '0)
                begin
                    job_next.status = ST_EMPTY;
                    job_next.y0     = '0;
                    state_next      = FS_PUSH;
                end
                else if (cursor_reg == '0)
                begin
                    job_next.status = ST_BELOW;
                    job_next.y0     = rd_y_reg;
                    state_next      = FS_PUSH;
                end
                else
                begin
                    if (cursor_reg >= cnt)
                    begin
                        job_next.status = ST_ABOVE;
                    end
                    else
                    begin
                        job_next.status = ST_INTERIOR;
                        job_next.x1     = rd_x_reg;
                        job_next.y1     = rd_y_reg;
                    end
                    rd_addr    = ADDR_W'(cursor_reg - 1'b1);
                    state_next = FS_FETCH;
                end
            end
            FS_FETCH:
            begin
                // Keep the lower bracket entry on the read port.
                rd_addr    = ADDR_W'(cursor_reg - 1'b1);
                state_next = FS_BRACKET;
            end
            FS_BRACKET:
            begin
                job_next.x0  = rd_x_reg;
                job_next.y0  = rd_y_reg;
                job_next.x_q = xq_reg;
                state_next   = FS_PUSH;
            end
            FS_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pli_back.sv
// Back end: blend factor division, multiply and rounding of the result; clamps pass y0 through.
module pli_back
    import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int NW = DATA_WIDTH + 1;
    localparam int QW = T_FRAC + 1;
    localparam int DIV_CNT_W = $clog2(T_FRAC + 1);

    back_state_t state_reg, state_next;
    job_t job_reg, job_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] den_reg, den_next;
    logic [NW:0] rem_reg, rem_next;
    logic [QW-1:0] t_reg, t_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic signed [NW+QW:0] prod_reg, prod_next;
    out_item_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        t_reg    <= t_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign job_ready = (state_reg == BS_IDLE);
    assign out_valid = (state_reg == BS_OUT);
    assign out_data  = res_reg;

    // Restoring division yields one quotient bit a cycle.
    always_comb
    begin
        logic signed [NW-1:0] num_s;
        logic signed [NW-1:0] den_s;
        logic [NW:0] trial;
        logic signed [NW+QW:0] dy;
        logic signed [NW+QW:0] sum;
        state_next = state_reg;
        job_next   = job_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        t_next     = t_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        num_s = $signed(num_reg);
        den_s = $signed(den_reg);
        trial = '0;
        dy  = (NW+QW+1)'($signed(job_reg.y1)) - (NW+QW+1)'($signed(job_reg.y0));
        sum = prod_reg + (NW+QW+1)'(1 << (T_FRAC - 1));
        case (state_reg)
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job_data;
                    state_next = BS_SETUP;
                end
            end
            BS_SETUP:
            begin
                num_next = NW'($signed(job_reg.x_q)) - NW'($signed(job_reg.x0));
                den_next = NW'($signed(job_reg.x1)) - NW'($signed(job_reg.x0));
                rem_next  = '0;
                t_next    = '0;
                step_next = '0;
                if (job_reg.status != ST_INTERIOR)
                begin
                    res_next.y_out  = job_reg.y0;
                    res_next.status = job_reg.status;
                    state_next      = BS_OUT;
                end
                else
                begin
                    state_next = BS_DIV;
                end
            end
            BS_DIV:
            begin
                if (num_s <= 0)
                begin
                    t_next     = '0;
                    state_next = BS_MUL;
                end
                else if (num_s >= den_s)
                begin
                    t_next     = QW'(1 << T_FRAC);
                    state_next = BS_MUL;
                end
                else
                begin
                    // Numerator is below den here, so the quotient fits in T_FRAC bits.
                    if (step_reg == '0)
                    begin
                        trial = {1'b0, num_reg} << 1;
                    end
                    else
                    begin
                        trial = rem_reg << 1;
                    end
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_next = trial - {1'b0, den_reg};
                        t_next   = {t_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial;
                        t_next   = {t_reg[QW-2:0], 1'b0};
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == DIV_CNT_W'(T_FRAC - 1))
                    begin
                        state_next = BS_MUL;
                    end
                end
            end
            BS_MUL:
            begin
                prod_next  = dy * $signed({1'b0, t_reg});
                state_next = BS_ROUND;
            end
            BS_ROUND:
            begin
                res_next.y_out  = job_reg.y0 + DATA_WIDTH'(sum >>> T_FRAC);
                res_next.status = ST_INTERIOR;
                state_next      = BS_OUT;
            end
            BS_OUT:
            begin
                if (out_ready)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/piecewise_linear_interp.sv
// Top level of the piecewise linear interpolator.
//  Channel | Direction | Handshake         | Payload
//  in      | input     | in_valid/in_ready | in_item_t  (action, start_req, x_value, y_value)
//  out     | output    | out_valid/out_ready | out_item_t (y_out, status)
// An append is written while the front end stays idle. A query runs read, a check per
// cursor step, then fetch and bracket when the bracketing entries come from the table RAM.
// The back end runs setup, 16 divider steps, multiply and round for an interior point, no
// divider steps when the blend factor saturates, and only setup for a clamp or empty table.
// Front and back each hold one request, so the next query searches while one divides.
// Reset empties the table count and cursor; stalls on out hold the back end.
module piecewise_linear_interp
    import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic job_valid;
    logic job_ready;
    job_t job_data;

    pli_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data)
    );

    pli_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // An empty table always answers zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.y_out == '0)
        else $error("empty table result not zero");

    // A held result keeps its value while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A job offered while the back end is busy stays held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job_data))
        else $error("queued job dropped");

endmodule
